[rtl/uer_pkg.sv]
// Shared types and constants for the ultrasonic echo ranger.
// No dependencies; imported by uer_cfg, uer_seq, uer_conv and the top level.
package uer_pkg;

  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  localparam int unsigned SettleW  = 16;
  localparam int unsigned PulseW   = 8;
  localparam int unsigned TimeoutW = 24;
  localparam int unsigned AttemptW = 4;
  localparam int unsigned TimerW   = 16;
  localparam int unsigned CountW   = 24;
  localparam int unsigned DistW    = 16;
  localparam int unsigned QuotW    = 23;   // (17*w + 500) / 8 below saturation
  localparam int unsigned RecipW   = 24;

  localparam logic [SettleW-1:0]  SettleRst  = 16'd10000;
  localparam logic [PulseW-1:0]   PulseRst   = 8'd10;
  localparam logic [TimeoutW-1:0] TimeoutRst = 24'd1000000;
  localparam logic [AttemptW-1:0] AttemptRst = 4'd10;

  localparam logic [CountW-1:0] CountMax = 24'hFFFFFF;

  // Widths at or above this give a distance of 65535 cm or more.
  localparam logic [CountW-1:0] SatWidth = 24'd3855030;

  // floor(y / 125) == (y * RecipMul) >> RecipShift for every y below 2**23.
  localparam logic [RecipW-1:0] RecipMul   = 24'd8589935;
  localparam int unsigned       RecipShift = 30;

  typedef enum logic [1:0] {
    REG_SETTLE  = 2'd0,
    REG_PULSE   = 2'd1,
    REG_TIMEOUT = 2'd2,
    REG_ATTEMPT = 2'd3
  } uer_reg_e;

  typedef struct packed {
    logic [SettleW-1:0]  settle_ticks;
    logic [PulseW-1:0]   pulse_ticks;
    logic [TimeoutW-1:0] timeout_ticks;
    logic [AttemptW-1:0] max_attempts;
  } uer_cfg_t;

  // Sequencer result, before the centimetre conversion.
  typedef struct packed {
    logic             trigger_level;
    logic             busy_res;
    logic             result_valid;
    logic             timed_out;
    logic             dist_sat;
    logic [QuotW-1:0] dist_quot;
  } uer_res_t;

endpackage

[rtl/uer_cfg.sv]
// APB-style register file for the echo ranger configuration.
// Depends on uer_pkg.
module uer_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [uer_pkg::AddrW-1:0] paddr,
  input  logic [uer_pkg::DataW-1:0] pwdata,
  output logic [uer_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output uer_pkg::uer_cfg_t         cfg_o
);
  import uer_pkg::*;

  uer_cfg_t cfg_q, cfg_d;
  uer_reg_e sel;
  logic     wr_en;

  assign sel    = uer_reg_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (sel)
        REG_SETTLE:  cfg_d.settle_ticks  = pwdata[SettleW-1:0];
        REG_PULSE:   cfg_d.pulse_ticks   = pwdata[PulseW-1:0];
        REG_TIMEOUT: cfg_d.timeout_ticks = pwdata[TimeoutW-1:0];
        REG_ATTEMPT: cfg_d.max_attempts  = pwdata[AttemptW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_SETTLE:  prdata = {{(DataW-SettleW){1'b0}}, cfg_q.settle_ticks};
      REG_PULSE:   prdata = {{(DataW-PulseW){1'b0}}, cfg_q.pulse_ticks};
      REG_TIMEOUT: prdata = {{(DataW-TimeoutW){1'b0}}, cfg_q.timeout_ticks};
      REG_ATTEMPT: prdata = {{(DataW-AttemptW){1'b0}}, cfg_q.max_attempts};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settle_ticks  <= SettleRst;
      cfg_q.pulse_ticks   <= PulseRst;
      cfg_q.timeout_ticks <= TimeoutRst;
      cfg_q.max_attempts  <= AttemptRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[rtl/uer_seq.sv]
// Ranging sequencer: phase state machine, attempt counting and the first
// result register. Depends on uer_pkg.
module uer_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  uer_pkg::uer_cfg_t cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              start_req_i,
  input  logic              echo_level_i,
  input  logic              take_i,
  output logic              res_valid_o,
  output uer_pkg::uer_res_t res_o
);
  import uer_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SETTLE = 3'd1,
    PH_PULSE  = 3'd2,
    PH_RISE   = 3'd3,
    PH_FALL   = 3'd4
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [TimerW-1:0]   timer_q, timer_d, timer_inc;
  logic [CountW-1:0]   elapsed_q, elapsed_d, elapsed_inc;
  logic [CountW-1:0]   width_q, width_d, width_inc;
  logic [AttemptW-1:0] att_q, att_d, att_inc;
  logic                res_valid_q;
  uer_res_t            res_q, res_d;
  logic                accept;
  logic                fail;
  logic [28:0]         x17;

  assign accept      = in_valid_i && (!res_valid_q || take_i);
  assign in_stall_o  = res_valid_q && !take_i;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assign timer_inc   = timer_q + TimerW'(1);
  assign elapsed_inc = (elapsed_q == CountMax) ? elapsed_q : elapsed_q + CountW'(1);
  assign width_inc   = (width_q == CountMax) ? width_q : width_q + CountW'(1);
  assign att_inc     = att_q + AttemptW'(1);

  // 17*w + 500, divided by 8 at the use; only meaningful below saturation
  assign x17 = {1'b0, width_q, 4'b0000} + {5'b00000, width_q} + 29'd500;

  always_comb begin
    phase_d   = phase_q;
    timer_d   = timer_q;
    elapsed_d = elapsed_q;
    width_d   = width_q;
    att_d     = att_q;
    fail      = 1'b0;
    res_d     = '0;

    unique case (phase_q)
      PH_SETTLE: begin
        timer_d = timer_inc;
        if (timer_inc >= cfg_i.settle_ticks || timer_inc == '0) begin
          phase_d = PH_PULSE;
          timer_d = '0;
        end
      end
      PH_PULSE: begin
        res_d.trigger_level = 1'b1;
        timer_d = timer_inc;
        if (timer_inc >= {{(TimerW-PulseW){1'b0}}, cfg_i.pulse_ticks} || timer_inc == '0) begin
          phase_d   = PH_RISE;
          timer_d   = '0;
          elapsed_d = '0;
          width_d   = '0;
        end
      end
      PH_RISE: begin
        elapsed_d = elapsed_inc;
        if (echo_level_i) begin
          phase_d = PH_FALL;
          width_d = CountW'(1);
        end else if (elapsed_inc >= cfg_i.timeout_ticks) begin
          fail = 1'b1;
        end
      end
      PH_FALL: begin
        elapsed_d = elapsed_inc;
        if (echo_level_i) begin
          width_d = width_inc;
          if (elapsed_inc >= cfg_i.timeout_ticks) begin
            fail = 1'b1;
          end
        end else begin
          res_d.result_valid = 1'b1;
          res_d.dist_sat     = (width_q >= SatWidth);
          res_d.dist_quot    = x17[25:3];
          phase_d            = PH_IDLE;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        if (start_req_i) begin
          phase_d = PH_SETTLE;
          timer_d = '0;
          att_d   = '0;
        end
      end
    endcase

    if (fail) begin
      att_d = att_inc;
      if (att_inc >= cfg_i.max_attempts || att_inc == '0) begin
        res_d.timed_out = 1'b1;
        phase_d         = PH_IDLE;
      end else begin
        phase_d = PH_SETTLE;
        timer_d = '0;
      end
    end

    res_d.busy_res = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      timer_q     <= '0;
      elapsed_q   <= '0;
      width_q     <= '0;
      att_q       <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (accept) begin
        phase_q     <= phase_d;
        timer_q     <= timer_d;
        elapsed_q   <= elapsed_d;
        width_q     <= width_d;
        att_q       <= att_d;
        res_q       <= res_d;
        res_valid_q <= 1'b1;
      end else if (take_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

endmodule

[rtl/uer_conv.sv]
// Centimetre conversion and output register of the echo ranger.
// Depends on uer_pkg.
module uer_conv (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  uer_pkg::uer_res_t res_i,
  output logic              take_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              trigger_level_o,
  output logic              busy_res_o,
  output logic              result_valid_o,
  output logic              timed_out_o,
  output logic [15:0]       distance_cm_o
);
  import uer_pkg::*;

  localparam int unsigned ProdW = QuotW + RecipW;

  logic             valid_q;
  logic             trig_q, busy_q, rv_q, tout_q;
  logic [DistW-1:0] dist_q, dist_d;
  logic [ProdW-1:0] prod;

  assign take_o = !valid_q || !out_stall_i;

  // floor(q / 125) by reciprocal multiply
  assign prod = {{RecipW{1'b0}}, res_i.dist_quot} * {{QuotW{1'b0}}, RecipMul};

  always_comb begin
    if (!res_i.result_valid) begin
      dist_d = '0;
    end else if (res_i.dist_sat) begin
      dist_d = '1;
    end else begin
      dist_d = prod[RecipShift+DistW-1:RecipShift];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      trig_q  <= 1'b0;
      busy_q  <= 1'b0;
      rv_q    <= 1'b0;
      tout_q  <= 1'b0;
      dist_q  <= '0;
    end else if (take_o) begin
      valid_q <= res_valid_i;
      if (res_valid_i) begin
        trig_q <= res_i.trigger_level;
        busy_q <= res_i.busy_res;
        rv_q   <= res_i.result_valid;
        tout_q <= res_i.timed_out;
        dist_q <= dist_d;
      end
    end
  end

  assign out_valid_o     = valid_q;
  assign trigger_level_o = trig_q;
  assign busy_res_o      = busy_q;
  assign result_valid_o  = rv_q;
  assign timed_out_o     = tout_q;
  assign distance_cm_o   = dist_q;

endmodule

[rtl/ultrasonic_echo_ranger_top.sv]
// Top level of the ultrasonic echo ranger: register file, sequencer and
// distance conversion. Depends on uer_pkg, uer_cfg, uer_seq and uer_conv.
//
//   Channel  | Handshake                | Payload
//   ---------+--------------------------+------------------------------------------
//   in       | in_valid_i / in_stall_o  | start_req_i, echo_level_i (one us tick)
//   out      | out_valid_o / out_stall_i| trigger_level_o, busy_res_o,
//            |                          | result_valid_o, timed_out_o, distance_cm_o
//   cfg      | APB psel/penable/pwrite  | paddr (4*index), pwdata, prdata
//
// One tick item is accepted per cycle while in_stall_o is low; each accepted
// item yields one result item, held first in the sequencer register and then
// in the conversion/output register.
// Reset (rst_ni low) returns to idle with the documented register defaults.
// A stall on a valid output holds the output register and a full sequencer
// register; the input stalls only when that register is full and cannot move on.
module ultrasonic_echo_ranger_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // tick input
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      start_req_i,
  input  logic                      echo_level_i,
  // result output
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      trigger_level_o,
  output logic                      busy_res_o,
  output logic                      result_valid_o,
  output logic                      timed_out_o,
  output logic [15:0]               distance_cm_o,
  // configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [uer_pkg::AddrW-1:0] paddr,
  input  logic [uer_pkg::DataW-1:0] pwdata,
  output logic [uer_pkg::DataW-1:0] prdata,
  output logic                      pready
);
  import uer_pkg::*;

  uer_cfg_t cfg;
  uer_res_t seq_res;
  logic     seq_valid;
  logic     take;

  // Hold the live configuration; writes apply at once.
  uer_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Advance the phase machine by one tick for every accepted item.
  uer_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .start_req_i  (start_req_i),
    .echo_level_i (echo_level_i),
    .take_i       (take),
    .res_valid_o  (seq_valid),
    .res_o        (seq_res)
  );

  // Convert echo width to centimetres and drive the output register.
  uer_conv u_conv (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .res_valid_i     (seq_valid),
    .res_i           (seq_res),
    .take_o          (take),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .trigger_level_o (trigger_level_o),
    .busy_res_o      (busy_res_o),
    .result_valid_o  (result_valid_o),
    .timed_out_o     (timed_out_o),
    .distance_cm_o   (distance_cm_o)
  );

endmodule

[rtl/uer_checker.sv]
// Port-level checks for the echo ranger, bound to the top level.
// Depends on ultrasonic_echo_ranger_top port names only.
module uer_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        trigger_level_o,
  input logic        busy_res_o,
  input logic        result_valid_o,
  input logic        timed_out_o,
  input logic [15:0] distance_cm_o
);

  // A finishing item leaves the block idle.
  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_valid_o || timed_out_o) |-> !busy_res_o)
    else $error("finish item shows busy");

  // Distance and timeout never report together.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_valid_o |-> !timed_out_o)
    else $error("distance and timeout in one item");

  // Distance is zero unless reported.
  a_dist_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !result_valid_o |-> distance_cm_o == 16'd0)
    else $error("distance without result_valid");

  // The trigger only goes high during a measurement.
  a_trig_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && trigger_level_o |-> busy_res_o)
    else $error("trigger high while idle");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(distance_cm_o))
    else $error("stalled result changed");

endmodule

bind ultrasonic_echo_ranger_top uer_checker u_uer_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .trigger_level_o (trigger_level_o),
  .busy_res_o      (busy_res_o),
  .result_valid_o  (result_valid_o),
  .timed_out_o     (timed_out_o),
  .distance_cm_o   (distance_cm_o)
);
